>>> rtl/mcfs_pkg.sv
// package of the multi-channel frame sequencer: field widths, codes and fsm states
// no dependencies

`default_nettype none

package mcfs_pkg;

  localparam int OP_W    = 3;
  localparam int CH_W    = 5;
  localparam int OFS_W   = 12;
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  // widest table address before wrap: offset + 2 + 3 * 255 + 2
  localparam int SUM_W   = 13;

  localparam logic [BYTE_W-1:0] END_LOOP = 8'd1;
  localparam logic [BYTE_W-1:0] END_HOLD = 8'd2;
  localparam logic [BYTE_W-1:0] NO_FRAME = 8'hFF;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 3'd0,
    OP_PLAY  = 3'd1,
    OP_STOP  = 3'd2,
    OP_TICK  = 3'd3,
    OP_INIT  = 3'd4
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    EV_STATUS = 2'd0,
    EV_APPLY  = 2'd1,
    EV_CLEAR  = 2'd2
  } ev_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_WRITE,
    ST_AP_BASE,
    ST_AP_FR_RD,
    ST_AP_FR,
    ST_AP_PAL_RD,
    ST_AP_PAL,
    ST_AP_DUR_RD,
    ST_AP_DUR,
    ST_TK_CHK,
    ST_TK_CNT_RD,
    ST_TK_CNT,
    ST_TK_MODE_RD,
    ST_TK_MODE,
    ST_TK_NEXT,
    ST_CLR,
    ST_BS_CHK,
    ST_BS_RD,
    ST_BS_CMP,
    ST_STATUS
  } state_e;

endpackage

`default_nettype wire

>>> rtl/mcfs_if.sv
// request and result channels of the frame sequencer
// depends on mcfs_pkg

`default_nettype none

interface mcfs_req_if import mcfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CH_W-1:0]   target;
  logic [OFS_W-1:0]  table_offset;
  logic [OFS_W-1:0]  store_address;
  logic [BYTE_W-1:0] store_byte;

  modport source (output valid, operation, target, table_offset, store_address, store_byte,
                  input ready);
  modport sink (input valid, operation, target, table_offset, store_address, store_byte,
                output ready);
endinterface

interface mcfs_res_if import mcfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [CH_W-1:0]   channel;
  logic [BYTE_W-1:0] frame;
  logic [BYTE_W-1:0] palette;
  logic              busy_res;
  logic              last;

  modport source (output valid, event_kind, channel, frame, palette, busy_res, last,
                  input ready);
  modport sink (input valid, event_kind, channel, frame, palette, busy_res, last,
                output ready);
endinterface

`default_nettype wire

>>> rtl/mcfs_store.sv
// script byte store: single port ram with registered read data
// depends on mcfs_pkg

`default_nettype none

module mcfs_store import mcfs_pkg::*; #(
  parameter int STORE_BYTES = 4096
) (
  input  wire logic                           clk_i,
  input  wire logic                           we_i,
  input  wire logic [$clog2(STORE_BYTES)-1:0] addr_i,
  input  wire logic [BYTE_W-1:0]              wdata_i,
  output      logic [BYTE_W-1:0]              rdata_o
);

  logic [BYTE_W-1:0] mem_q [STORE_BYTES];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/multi_channel_frame_sequencer.sv
// multi-channel frame sequencer top level: sequencer, channel state, output register
// depends on mcfs_pkg, mcfs_if and mcfs_store
//
// usage:
//   req_i takes one request at a time (write_script, play, stop, tick, init); ready is
//   high only while the sequencer is idle. res_o returns the apply and clear events the
//   request causes, then one status result with last set and the busy flag.
//   all table reads go through one store port and one address register with a
//   compare-and-subtract wrap unit; each read subtracts the store size until the
//   address is in range, then takes the registered read data in the next state.
//   steps per request:
//     write, stop, init: the store write or the clear, then the busy scan
//     play: the step fetch, then the busy scan
//     tick: a check of every channel, a count and mode read plus a step fetch for
//       each channel that applies a step, a count and mode read for each that holds or clears
//     busy scan: a mode read for each running channel (ends early when busy)
//   the output register lets the next request in while the status result waits;
//   a stalled receiver holds the sequencer in the emitting state.
//   reset clears all channels and the output; the store is not cleared and must be
//   written before tables are played.

`default_nettype none

module multi_channel_frame_sequencer import mcfs_pkg::*; #(
  parameter int CHANNELS    = 25,
  parameter int STORE_BYTES = 4096
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mcfs_req_if.sink    req_i,
  mcfs_res_if.source  res_o
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int RW = (AW > SUM_W) ? AW : SUM_W;
  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [RW:0]   StoreLim = (RW+1)'(STORE_BYTES);
  localparam logic [IW-1:0] LastIdx  = IW'(CHANNELS - 1);

  state_e state_q, state_d;
  op_e    op_q;
  logic [IW-1:0] ch_q, ch_d;

  logic              chan_active_q  [CHANNELS];
  logic              chan_running_q [CHANNELS];
  logic [OFS_W-1:0]  chan_offset_q  [CHANNELS];
  logic [BYTE_W-1:0] chan_step_q    [CHANNELS];
  logic [BYTE_W-1:0] chan_timer_q   [CHANNELS];

  logic [RW-1:0]     addr_q;
  logic [BYTE_W-1:0] byte_q, frame_q, pal_q, count_q;
  logic              busy_q;
  logic [BYTE_W-1:0] rdata;

  logic              out_valid_q;
  ev_e               out_kind_q;
  logic [CH_W-1:0]   out_ch_q;
  logic [BYTE_W-1:0] out_frame_q, out_pal_q;
  logic              out_busy_q, out_last_q;

  logic              req_acc, out_free, need_wrap, tgt_ok, cur_live, end_of_table;
  op_e               req_op;
  logic [IW-1:0]     tgt_idx;
  logic [BYTE_W-1:0] timer_dec, step_inc;
  logic [RW-1:0]     ap_base;

  logic              emit, store_we;
  ev_e               emit_kind;
  logic [BYTE_W-1:0] emit_frame, emit_pal;
  logic              emit_busy, emit_last;

  assign req_acc      = req_i.valid && req_i.ready;
  assign req_op       = op_e'(req_i.operation);
  assign tgt_ok       = {1'b0, req_i.target} < (CH_W+1)'(CHANNELS);
  assign tgt_idx      = req_i.target[IW-1:0];
  assign out_free     = !out_valid_q || res_o.ready;
  assign need_wrap    = {1'b0, addr_q} >= StoreLim;
  assign cur_live     = chan_active_q[ch_q] && chan_running_q[ch_q];
  assign timer_dec    = chan_timer_q[ch_q] - 8'd1;
  assign step_inc     = chan_step_q[ch_q] + 8'd1;
  assign end_of_table = step_inc >= count_q;
  assign ap_base      = RW'(chan_offset_q[ch_q]) + RW'(2)
                      + RW'({chan_step_q[ch_q], 1'b0}) + RW'(chan_step_q[ch_q]);

  mcfs_store #(
    .STORE_BYTES (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .addr_i  (addr_q[AW-1:0]),
    .wdata_i (byte_q),
    .rdata_o (rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          case (req_op)
            OP_WRITE: state_d = ST_WRITE;
            OP_PLAY:  state_d = tgt_ok ? ST_AP_BASE : ST_BS_CHK;
            OP_STOP:  state_d = (tgt_ok && chan_active_q[tgt_idx]) ? ST_CLR : ST_BS_CHK;
            OP_TICK:  state_d = ST_TK_CHK;
            OP_INIT:  state_d = ST_CLR;
            default:  state_d = ST_BS_CHK;
          endcase
        end
      end
      ST_WRITE:      if (!need_wrap) state_d = ST_BS_CHK;
      ST_AP_BASE:    state_d = ST_AP_FR_RD;
      ST_AP_FR_RD:   if (!need_wrap) state_d = ST_AP_FR;
      ST_AP_FR:      state_d = ST_AP_PAL_RD;
      ST_AP_PAL_RD:  if (!need_wrap) state_d = ST_AP_PAL;
      ST_AP_PAL:     state_d = ST_AP_DUR_RD;
      ST_AP_DUR_RD:  if (!need_wrap) state_d = ST_AP_DUR;
      ST_AP_DUR: begin
        if (out_free) state_d = (op_q == OP_TICK) ? ST_TK_NEXT : ST_BS_CHK;
      end
      ST_TK_CHK:     state_d = (cur_live && timer_dec == '0) ? ST_TK_CNT_RD : ST_TK_NEXT;
      ST_TK_CNT_RD:  if (!need_wrap) state_d = ST_TK_CNT;
      ST_TK_CNT:     state_d = ST_TK_MODE_RD;
      ST_TK_MODE_RD: if (!need_wrap) state_d = ST_TK_MODE;
      ST_TK_MODE: begin
        if (!end_of_table || rdata == END_LOOP) state_d = ST_AP_BASE;
        else if (rdata == END_HOLD)             state_d = ST_TK_NEXT;
        else                                    state_d = ST_CLR;
      end
      ST_TK_NEXT:    state_d = (ch_q == LastIdx) ? ST_BS_CHK : ST_TK_CHK;
      ST_CLR: begin
        if (out_free) state_d = (op_q == OP_TICK) ? ST_TK_NEXT : ST_BS_CHK;
      end
      ST_BS_CHK: begin
        if (cur_live)             state_d = ST_BS_RD;
        else if (ch_q == LastIdx) state_d = ST_STATUS;
      end
      ST_BS_RD:      if (!need_wrap) state_d = ST_BS_CMP;
      ST_BS_CMP: begin
        if (rdata != END_LOOP || ch_q == LastIdx) state_d = ST_STATUS;
        else                                      state_d = ST_BS_CHK;
      end
      ST_STATUS:     if (out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // channel index
  always_comb begin
    ch_d = ch_q;
    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          case (req_op)
            OP_PLAY: ch_d = tgt_ok ? tgt_idx : '0;
            OP_STOP: ch_d = tgt_ok ? tgt_idx : '0;
            OP_INIT: ch_d = LastIdx;
            default: ch_d = '0;
          endcase
        end
      end
      ST_TK_NEXT: if (ch_q != LastIdx) ch_d = ch_q + IW'(1);
      ST_BS_CHK:  if (!cur_live && ch_q != LastIdx) ch_d = ch_q + IW'(1);
      ST_BS_CMP:  if (rdata == END_LOOP && ch_q != LastIdx) ch_d = ch_q + IW'(1);
      default: ;
    endcase
    // busy scan starts from channel 0
    if (state_d == ST_BS_CHK && state_q != ST_BS_CHK && state_q != ST_BS_CMP) begin
      ch_d = '0;
    end
  end

  // outputs of the sequencer
  always_comb begin
    emit       = 1'b0;
    emit_kind  = EV_STATUS;
    emit_frame = '0;
    emit_pal   = '0;
    emit_busy  = 1'b0;
    emit_last  = 1'b0;
    store_we   = 1'b0;
    case (state_q)
      ST_WRITE: store_we = !need_wrap;
      ST_AP_DUR: begin
        emit       = out_free;
        emit_kind  = EV_APPLY;
        emit_frame = frame_q;
        emit_pal   = pal_q;
      end
      ST_CLR: begin
        emit       = out_free;
        emit_kind  = EV_CLEAR;
        emit_frame = NO_FRAME;
      end
      ST_STATUS: begin
        emit      = out_free;
        emit_busy = busy_q;
        emit_last = 1'b1;
      end
      default: ;
    endcase
  end

  // control and channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_WRITE;
      ch_q    <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        chan_active_q[i]  <= 1'b0;
        chan_running_q[i] <= 1'b0;
        chan_offset_q[i]  <= '0;
        chan_step_q[i]    <= '0;
        chan_timer_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      case (state_q)
        ST_IDLE: begin
          if (req_acc) begin
            op_q <= req_op;
            case (req_op)
              OP_PLAY: begin
                if (tgt_ok) begin
                  chan_active_q[tgt_idx]  <= 1'b1;
                  chan_running_q[tgt_idx] <= 1'b1;
                  chan_offset_q[tgt_idx]  <= req_i.table_offset;
                  chan_step_q[tgt_idx]    <= '0;
                end
              end
              OP_INIT: begin
                for (int i = 0; i < CHANNELS; i++) begin
                  chan_active_q[i]  <= 1'b0;
                  chan_running_q[i] <= 1'b0;
                  chan_step_q[i]    <= '0;
                  chan_timer_q[i]   <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_AP_DUR: begin
          if (out_free) chan_timer_q[ch_q] <= (rdata == '0) ? 8'd1 : rdata;
        end
        ST_TK_CHK: if (cur_live) chan_timer_q[ch_q] <= timer_dec;
        ST_TK_MODE: begin
          if (!end_of_table)          chan_step_q[ch_q]    <= step_inc;
          else if (rdata == END_LOOP) chan_step_q[ch_q]    <= '0;
          else if (rdata == END_HOLD) chan_running_q[ch_q] <= 1'b0;
        end
        ST_CLR:     if (out_free) chan_active_q[ch_q] <= 1'b0;
        default: ;
      endcase
    end
  end

  // address unit and fetched bytes
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          addr_q <= RW'(req_i.store_address);
          byte_q <= req_i.store_byte;
          busy_q <= 1'b0;
        end
      end
      ST_WRITE, ST_AP_FR_RD, ST_AP_PAL_RD, ST_AP_DUR_RD, ST_TK_CNT_RD, ST_TK_MODE_RD,
      ST_BS_RD: begin
        if (need_wrap) addr_q <= addr_q - StoreLim[RW-1:0];
      end
      ST_AP_BASE: addr_q <= ap_base;
      ST_AP_FR: begin
        frame_q <= rdata;
        addr_q  <= addr_q + RW'(1);
      end
      ST_AP_PAL: begin
        pal_q  <= rdata;
        addr_q <= addr_q + RW'(1);
      end
      ST_TK_CHK: if (cur_live && timer_dec == '0) addr_q <= RW'(chan_offset_q[ch_q]);
      ST_TK_CNT: begin
        count_q <= rdata;
        addr_q  <= addr_q + RW'(1);
      end
      ST_BS_CHK: if (cur_live) addr_q <= RW'(chan_offset_q[ch_q]) + RW'(1);
      ST_BS_CMP: if (rdata != END_LOOP) busy_q <= 1'b1;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q  <= emit_kind;
      out_ch_q    <= (emit_kind == EV_STATUS) ? '0 : CH_W'(ch_q);
      out_frame_q <= emit_frame;
      out_pal_q   <= emit_pal;
      out_busy_q  <= emit_busy;
      out_last_q  <= emit_last;
    end
  end

  assign req_i.ready      = (state_q == ST_IDLE);
  assign res_o.valid      = out_valid_q;
  assign res_o.event_kind = out_kind_q;
  assign res_o.channel    = out_ch_q;
  assign res_o.frame      = out_frame_q;
  assign res_o.palette    = out_pal_q;
  assign res_o.busy_res   = out_busy_q;
  assign res_o.last       = out_last_q;

endmodule

`default_nettype wire

>>> rtl/mcfs_checker.sv
// port-level checks of the frame sequencer, bound to the top level
// depends on mcfs_pkg and multi_channel_frame_sequencer

`default_nettype none

module mcfs_checker import mcfs_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              req_valid_i,
  input wire logic              req_ready_i,
  input wire logic              res_valid_i,
  input wire logic              res_ready_i,
  input wire logic [KIND_W-1:0] res_kind_i,
  input wire logic [CH_W-1:0]   res_channel_i,
  input wire logic [BYTE_W-1:0] res_frame_i,
  input wire logic [BYTE_W-1:0] res_palette_i,
  input wire logic              res_busy_i,
  input wire logic              res_last_i
);

  // stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i
      && $stable({res_kind_i, res_channel_i, res_frame_i, res_palette_i,
                  res_busy_i, res_last_i}))
    else $error("stalled result changed");

  // one request at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

  // status is the only and always the closing result
  a_last_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_last_i == (res_kind_i == EV_STATUS)))
    else $error("last flag does not match status");

  // a clear carries no override and no busy flag
  a_clear_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_kind_i == EV_CLEAR |->
      res_frame_i == NO_FRAME && res_palette_i == '0 && !res_busy_i)
    else $error("bad clear result");

endmodule

bind multi_channel_frame_sequencer mcfs_checker u_mcfs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_kind_i    (res_o.event_kind),
  .res_channel_i (res_o.channel),
  .res_frame_i   (res_o.frame),
  .res_palette_i (res_o.palette),
  .res_busy_i    (res_o.busy_res),
  .res_last_i    (res_o.last)
);

`default_nettype wire

>>> bench/tb.sv
// testbench of the multi-channel frame sequencer: directed and random requests, with
// a self-contained channel predictor that checks every apply, clear and status result
// depends on mcfs_pkg, mcfs_if and multi_channel_frame_sequencer
`timescale 1ns / 1ps

module tb;
  import mcfs_pkg::*;

  localparam int CHANNELS    = 25;
  localparam int STORE_BYTES = 4096;
  localparam int HERO        = CHANNELS - 1;
  localparam int N_ITEMS     = 430;
  localparam int NSLOTS      = 6;

  localparam logic [BYTE_W-1:0] END_NORMAL = 8'd0;
  localparam logic [BYTE_W-1:0] END_ODD    = 8'h07;
  localparam logic [OP_W-1:0]   OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0]   OP_SPARE_HI = 3'd7;
  localparam logic [CH_W-1:0]   NO_CHANNEL  = 5'd31;

  typedef struct packed {
    ev_e               kind;
    logic [CH_W-1:0]   channel;
    logic [BYTE_W-1:0] frame;
    logic [BYTE_W-1:0] palette;
    logic              busy;
    logic              last;
  } override_ev_t;

  class override_predictor;
    bit [BYTE_W-1:0] store_mem [STORE_BYTES];
    bit              ch_on [CHANNELS];
    bit [OFS_W-1:0]  ch_ofs [CHANNELS];
    bit [7:0]        ch_step [CHANNELS];
    bit [7:0]        ch_timer [CHANNELS];
    bit              ch_run [CHANNELS];
    override_ev_t    pending [$];
    int              mismatches;
    int              checked;
    int              applies;
    int              clears;

    function bit [BYTE_W-1:0] peek(int unsigned a);
      return store_mem[a % STORE_BYTES];
    endfunction

    function void push(ev_e kind, int c, bit [BYTE_W-1:0] fr, bit [BYTE_W-1:0] pal,
                       bit busy);
      override_ev_t e;
      e.kind    = kind;
      e.channel = c[CH_W-1:0];
      e.frame   = fr;
      e.palette = pal;
      e.busy    = busy;
      e.last    = (kind == EV_STATUS);
      pending.push_back(e);
    endfunction

    function void apply_step(int c);
      int unsigned     base;
      bit [BYTE_W-1:0] dur;
      base = ch_ofs[c] + 2 + 3 * ch_step[c];
      dur  = peek(base + 2);
      ch_timer[c] = (dur == 0) ? 8'd1 : dur;
      push(EV_APPLY, c, peek(base), peek(base + 1), 1'b0);
    endfunction

    function void drop_channel(int c);
      if (ch_on[c]) begin
        ch_on[c] = 1'b0;
        push(EV_CLEAR, c, NO_FRAME, 8'd0, 1'b0);
      end
    endfunction

    function bit any_busy();
      for (int c = 0; c < CHANNELS; c++)
        if (ch_on[c] && ch_run[c] && peek(ch_ofs[c] + 1) != END_LOOP) return 1'b1;
      return 1'b0;
    endfunction

    function void take_request(logic [OP_W-1:0] op, logic [CH_W-1:0] tgt,
                               logic [OFS_W-1:0] ofs, logic [OFS_W-1:0] addr,
                               logic [BYTE_W-1:0] byt);
      bit [BYTE_W-1:0] count;
      bit [BYTE_W-1:0] mode;
      case (op)
        OP_WRITE: store_mem[addr % STORE_BYTES] = byt;
        OP_PLAY: begin
          if (tgt < CHANNELS) begin
            ch_on[tgt]   = 1'b1;
            ch_ofs[tgt]  = ofs;
            ch_step[tgt] = 8'd0;
            ch_run[tgt]  = 1'b1;
            apply_step(tgt);
          end
        end
        OP_STOP: if (tgt < CHANNELS) drop_channel(tgt);
        OP_TICK: begin
          for (int c = 0; c < CHANNELS; c++) begin
            if (ch_on[c] && ch_run[c]) begin
              ch_timer[c] = ch_timer[c] - 8'd1;
              if (ch_timer[c] == 0) begin
                count = peek(ch_ofs[c]);
                mode  = peek(ch_ofs[c] + 1);
                ch_step[c] = ch_step[c] + 8'd1;
                if (ch_step[c] >= count) begin
                  if (mode == END_LOOP) begin
                    ch_step[c] = 8'd0;
                    apply_step(c);
                  end else if (mode == END_HOLD) begin
                    ch_run[c] = 1'b0;
                  end else begin
                    drop_channel(c);
                  end
                end else begin
                  apply_step(c);
                end
              end
            end
          end
        end
        OP_INIT: begin
          for (int c = 0; c < CHANNELS; c++) begin
            ch_on[c]    = 1'b0;
            ch_step[c]  = 8'd0;
            ch_timer[c] = 8'd0;
            ch_run[c]   = 1'b0;
          end
          push(EV_CLEAR, HERO, NO_FRAME, 8'd0, 1'b0);
        end
        default: ;
      endcase
      push(EV_STATUS, 0, 8'd0, 8'd0, any_busy());
    endfunction

    task flag_mismatch(string what, logic [7:0] got, logic [7:0] want);
      mismatches++;
      $display("[%0t] mismatch on result %0d: %s got %h want %h",
               $realtime, checked, what, got, want);
    endtask

    task check_event(override_ev_t got);
      override_ev_t want;
      if (pending.size() == 0) begin
        flag_mismatch("unexpected result, kind", got.kind, 8'd0);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.kind === EV_APPLY) applies++;
      if (got.kind === EV_CLEAR) clears++;
      if (got.kind !== want.kind) flag_mismatch("event_kind", got.kind, want.kind);
      if (got.channel !== want.channel) flag_mismatch("channel", got.channel, want.channel);
      if (got.frame !== want.frame) flag_mismatch("frame", got.frame, want.frame);
      if (got.palette !== want.palette) flag_mismatch("palette", got.palette, want.palette);
      if (got.busy !== want.busy) flag_mismatch("busy_res", got.busy, want.busy);
      if (got.last !== want.last) flag_mismatch("last", got.last, want.last);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   calm = 1'b0;
  int   n_sent = 0;
  int   n_directed = 0;
  bit   slot_ready [NSLOTS];

  override_predictor pred = new();

  mcfs_req_if req_ch ();
  mcfs_res_if res_ch ();

  multi_channel_frame_sequencer #(
    .CHANNELS    (CHANNELS),
    .STORE_BYTES (STORE_BYTES)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .res_o  (res_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // table slots; the first one wraps past the top of the store
  function automatic logic [OFS_W-1:0] slot_base(int s);
    case (s)
      0:       return 12'hFFF;
      1:       return 12'h555;
      2:       return 12'hAAA;
      3:       return 12'h123;
      4:       return 12'h800;
      default: return 12'h3C0;
    endcase
  endfunction

  function automatic int slot_cap(int s);
    return (s == 0) ? 2 : 4;
  endfunction

  function automatic int slot_bytes(int s);
    return 2 + 3 * slot_cap(s);
  endfunction

  function automatic logic [OFS_W-1:0] slot_addr(int s, int i);
    logic [OFS_W-1:0] a;
    a = slot_base(s) + i;
    return a;
  endfunction

  function automatic int pick_wait();
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic [CH_W-1:0] pick_target();
    logic [CH_W-1:0] t;
    if ($urandom_range(0, 9) == 0) t = $urandom_range(CHANNELS, 31);
    else t = $urandom_range(0, CHANNELS - 1);
    return t;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_mode();
    logic [BYTE_W-1:0] m;
    case ($urandom_range(0, 3))
      0:       m = END_NORMAL;
      1:       m = END_LOOP;
      2:       m = END_HOLD;
      default: m = $urandom;
    endcase
    return m;
  endfunction

  function automatic int pick_ready_slot();
    int s0;
    s0 = $urandom_range(0, NSLOTS - 1);
    for (int k = 0; k < NSLOTS; k++)
      if (slot_ready[(s0 + k) % NSLOTS]) return (s0 + k) % NSLOTS;
    return -1;
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input logic [CH_W-1:0] tgt,
                              input logic [OFS_W-1:0] ofs, input logic [OFS_W-1:0] addr,
                              input logic [BYTE_W-1:0] byt);
    int gap;
    gap = pick_wait();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid         <= 1'b1;
    req_ch.operation     <= op;
    req_ch.target        <= tgt;
    req_ch.table_offset  <= ofs;
    req_ch.store_address <= addr;
    req_ch.store_byte    <= byt;
    do @(posedge clk_i); while (!req_ch.ready);
    pred.take_request(op, tgt, ofs, addr, byt);
    n_sent++;
  endtask

  task automatic write_byte(input logic [OFS_W-1:0] addr, input logic [BYTE_W-1:0] byt);
    send_request(OP_WRITE, $urandom, $urandom, addr, byt);
  endtask

  task automatic start_channel(input logic [CH_W-1:0] tgt, input logic [OFS_W-1:0] ofs);
    send_request(OP_PLAY, tgt, ofs, $urandom, $urandom);
  endtask

  task automatic plain_request(input logic [OP_W-1:0] op, input logic [CH_W-1:0] tgt);
    send_request(op, tgt, $urandom, $urandom, $urandom);
  endtask

  task automatic load_slot(input int s, input int cnt, input logic [BYTE_W-1:0] mode,
                           input bit extremes);
    logic [BYTE_W-1:0] fr;
    logic [BYTE_W-1:0] pal;
    logic [BYTE_W-1:0] dur;
    logic [BYTE_W-1:0] cnt_b;
    cnt_b = cnt;
    write_byte(slot_addr(s, 0), cnt_b);
    write_byte(slot_addr(s, 1), mode);
    for (int k = 0; k < slot_cap(s); k++) begin
      if (extremes) begin
        fr  = (k == 0) ? 8'h00 : 8'hFF;
        pal = ~fr;
        dur = k;
      end else begin
        fr  = $urandom;
        pal = $urandom;
        if ($urandom_range(0, 15) == 0) dur = $urandom;
        else dur = $urandom_range(0, 3);
      end
      write_byte(slot_addr(s, 2 + 3 * k), fr);
      write_byte(slot_addr(s, 3 + 3 * k), pal);
      write_byte(slot_addr(s, 4 + 3 * k), dur);
    end
    slot_ready[s] = 1'b1;
  endtask

  initial begin : result_sink
    override_ev_t got;
    int           stall;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = pick_wait();
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
      got.kind    = ev_e'(res_ch.event_kind);
      got.channel = res_ch.channel;
      got.frame   = res_ch.frame;
      got.palette = res_ch.palette;
      got.busy    = res_ch.busy_res;
      got.last    = res_ch.last;
      pred.check_event(got);
    end
  end

  initial begin : stimulus
    int               pick;
    int               s;
    int               i;
    logic [OFS_W-1:0] a;
    logic [BYTE_W-1:0] b;
    rst_ni               = 1'b0;
    req_ch.valid         = 1'b0;
    req_ch.operation     = OP_TICK;
    req_ch.target        = '0;
    req_ch.table_offset  = '0;
    req_ch.store_address = '0;
    req_ch.store_byte    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // looping two-step table across the store wrap, zero duration on step 0
    load_slot(0, 2, END_LOOP, 1'b1);
    start_channel(HERO, slot_base(0));
    plain_request(OP_TICK, $urandom);
    plain_request(OP_TICK, $urandom);
    write_byte(slot_addr(0, 1), END_HOLD);
    plain_request(OP_TICK, $urandom);
    plain_request(OP_TICK, $urandom);
    start_channel(NO_CHANNEL, slot_base(0));
    start_channel(5'd5, slot_base(0));
    start_channel(5'd5, slot_base(0));
    plain_request(OP_STOP, HERO);
    plain_request(OP_STOP, HERO);
    // empty table with an unknown end mode
    write_byte(slot_addr(0, 0), 8'd0);
    write_byte(slot_addr(0, 1), END_ODD);
    plain_request(OP_TICK, $urandom);
    start_channel(5'd6, slot_base(0));
    plain_request(OP_INIT, $urandom);
    plain_request(OP_SPARE_HI, $urandom);
    n_directed = n_sent;

    while (n_sent < N_ITEMS) begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      pick = $urandom_range(0, 99);
      s = pick_ready_slot();
      if (pick < 10 || s < 0) begin
        s = $urandom_range(0, NSLOTS - 1);
        load_slot(s, $urandom_range(0, slot_cap(s)), pick_mode(), 1'b0);
        start_channel(pick_target(), slot_base(s));
      end else if (pick < 50) begin
        plain_request(OP_TICK, $urandom);
      end else if (pick < 68) begin
        start_channel(pick_target(), slot_base(s));
      end else if (pick < 78) begin
        plain_request(OP_STOP, pick_target());
      end else if (pick < 88) begin
        i = $urandom_range(0, slot_bytes(s) - 1);
        if (i == 0) b = $urandom_range(0, slot_cap(s));
        else b = $urandom;
        write_byte(slot_addr(s, i), b);
      end else if (pick < 95) begin
        a = $urandom;
        b = $urandom;
        // step counts must never point past the written part of a table
        for (int k = 0; k < NSLOTS; k++)
          if (a == slot_base(k)) b = $urandom_range(0, slot_cap(k));
        write_byte(a, b);
      end else if (pick < 97) begin
        plain_request(OP_INIT, $urandom);
      end else begin
        plain_request($urandom_range(OP_SPARE_LO, OP_SPARE_HI), $urandom);
      end
    end
    req_ch.valid <= 1'b0;

    while (pred.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("covered %0d requests (%0d directed) over %0d table slots",
             n_sent, n_directed, NSLOTS);
    $display("checked %0d results: %0d applies, %0d clears, %0d mismatches",
             pred.checked, pred.applies, pred.clears, pred.mismatches);
    if (pred.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("timeout with %0d results outstanding", pred.pending.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
